### rtl/button_debounce_long_press_events_defines.svh
// Assertion macros for the button debounce block.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_EVENTS_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_EVENTS_DEFINES_SVH

`ifndef SYNTH
`define BDLP_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define BDLP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define BDLP_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define BDLP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/bdlp_pkg.sv
// Types and constants for the button debounce block.
package bdlp_pkg;

   localparam int unsigned TimeWidth  = 32;
   localparam int unsigned MsWidth    = 16;
   localparam int unsigned CsrIdxWidth = 2;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_PRESSED  = 3'd1,
      EV_RELEASED = 3'd2,
      EV_SHORT    = 3'd3,
      EV_LONG     = 3'd4,
      EV_MODE_ON  = 3'd5,
      EV_MODE_OFF = 3'd6
   } event_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_BUTTON_ENABLE = 2'd0,
      CSR_ACTIVE_LOW    = 2'd1,
      CSR_DEBOUNCE_MS   = 2'd2,
      CSR_LONG_PRESS_MS = 2'd3
   } csr_index_type;

   localparam logic               ResetButtonEnable = 1'b1;
   localparam logic               ResetActiveLow    = 1'b1;
   localparam logic [MsWidth-1:0] ResetDebounceMs   = 16'd20;
   localparam logic [MsWidth-1:0] ResetLongPressMs  = 16'd1000;

endpackage

### rtl/button_debounce_long_press_events.sv
// Button debouncer with press, release, long-press and analog-mode events.
// Each request word is one update: millisecond time, raw pin level, analog-mode bit
// and a consume flag. The pin level is debounced against debounce_ms, a held press
// raises one long-press event after long_press_ms, and a change of the mode bit raises
// a mode on or mode off event. A single event register keeps the first unread event
// until a word with consume_event set clears it after reporting. Every request word
// yields one response word carrying the pending event and the debounced state. The
// whole update runs combinationally from the accepted word into the state and response
// registers, so a word is taken every cycle; the response register only stalls the
// request side while a response is held by rsp_ready.
module button_debounce_long_press_events (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [bdlp_pkg::TimeWidth-1:0]       req_now_ms,
   input  logic                                 req_pin_level,
   input  logic                                 req_analog_mode,
   input  logic                                 req_consume_event,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [2:0]                           rsp_pending_event,
   output logic                                 rsp_button_pressed,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bdlp_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [bdlp_pkg::MsWidth-1:0]         csr_data
);

`include "button_debounce_long_press_events_defines.svh"

   logic                              button_enable_ff;
   logic                              active_low_ff;
   logic [bdlp_pkg::MsWidth-1:0]      debounce_ms_ff;
   logic [bdlp_pkg::MsWidth-1:0]      long_press_ms_ff;

   logic                              raw_seen_ff, raw_seen_in;
   logic [bdlp_pkg::TimeWidth-1:0]    changed_time_ff, changed_time_in;
   logic                              stable_pressed_ff, stable_pressed_in;
   logic [bdlp_pkg::TimeWidth-1:0]    press_time_ff, press_time_in;
   logic                              long_sent_ff, long_sent_in;
   logic                              last_mode_ff, last_mode_in;
   bdlp_pkg::event_type               event_ff, event_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   bdlp_pkg::event_type               rsp_event_ff, rsp_event_in;
   logic                              rsp_pressed_ff, rsp_pressed_in;

   logic                              req_fire;
   logic                              raw;
   logic                              raw_change;
   logic [bdlp_pkg::TimeWidth-1:0]    since_change;
   logic [bdlp_pkg::TimeWidth-1:0]    since_press;
   logic                              debounce_done;
   logic                              accept_level;
   logic                              long_hit;
   bdlp_pkg::event_type               ev;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         button_enable_ff <= bdlp_pkg::ResetButtonEnable;
         active_low_ff    <= bdlp_pkg::ResetActiveLow;
         debounce_ms_ff   <= bdlp_pkg::ResetDebounceMs;
         long_press_ms_ff <= bdlp_pkg::ResetLongPressMs;
      end else if (csr_valid) begin
         case (bdlp_pkg::csr_index_type'(csr_index))
            bdlp_pkg::CSR_BUTTON_ENABLE: button_enable_ff <= csr_data[0];
            bdlp_pkg::CSR_ACTIVE_LOW:    active_low_ff    <= csr_data[0];
            bdlp_pkg::CSR_DEBOUNCE_MS:   debounce_ms_ff   <= csr_data;
            bdlp_pkg::CSR_LONG_PRESS_MS: long_press_ms_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // elapsed times; a fresh change or fresh press means zero elapsed
   assign raw          = active_low_ff ? !req_pin_level : req_pin_level;
   assign raw_change   = raw != raw_seen_ff;
   assign since_change = req_now_ms - changed_time_ff;
   assign since_press  = req_now_ms - press_time_ff;
   assign debounce_done = raw_change ? (debounce_ms_ff == '0)
                                     : (since_change >= {16'd0, debounce_ms_ff});
   assign accept_level = button_enable_ff && debounce_done && (stable_pressed_ff != raw);
   assign long_hit = button_enable_ff && (accept_level
                     ? (raw && (long_press_ms_ff == '0))
                     : (stable_pressed_ff && !long_sent_ff &&
                        (since_press >= {16'd0, long_press_ms_ff})));

   always_comb begin
      raw_seen_in       = raw_seen_ff;
      changed_time_in   = changed_time_ff;
      stable_pressed_in = stable_pressed_ff;
      press_time_in     = press_time_ff;
      long_sent_in      = long_sent_ff;
      last_mode_in      = last_mode_ff;
      ev                = event_ff;
      if (button_enable_ff && raw_change) begin
         raw_seen_in     = raw;
         changed_time_in = req_now_ms;
      end
      if (accept_level) begin
         stable_pressed_in = raw;
         if (raw) begin
            press_time_in = req_now_ms;
            long_sent_in  = 1'b0;
            if (ev == bdlp_pkg::EV_NONE) ev = bdlp_pkg::EV_PRESSED;
         end else begin
            // short press would follow release and is always dropped
            if (ev == bdlp_pkg::EV_NONE) ev = bdlp_pkg::EV_RELEASED;
         end
      end
      if (long_hit) begin
         long_sent_in = 1'b1;
         if (ev == bdlp_pkg::EV_NONE) ev = bdlp_pkg::EV_LONG;
      end
      if (req_analog_mode != last_mode_ff) begin
         last_mode_in = req_analog_mode;
         if (ev == bdlp_pkg::EV_NONE)
            ev = req_analog_mode ? bdlp_pkg::EV_MODE_ON : bdlp_pkg::EV_MODE_OFF;
      end
      event_in = req_consume_event ? bdlp_pkg::EV_NONE : ev;
   end

   always_comb begin
      rsp_event_in   = rsp_event_ff;
      rsp_pressed_in = rsp_pressed_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      if (req_fire) begin
         rsp_valid_in   = 1'b1;
         rsp_event_in   = ev;
         rsp_pressed_in = stable_pressed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_seen_ff       <= 1'b0;
         changed_time_ff   <= '0;
         stable_pressed_ff <= 1'b0;
         press_time_ff     <= '0;
         long_sent_ff      <= 1'b0;
         last_mode_ff      <= 1'b0;
         event_ff          <= bdlp_pkg::EV_NONE;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (req_fire) begin
            raw_seen_ff       <= raw_seen_in;
            changed_time_ff   <= changed_time_in;
            stable_pressed_ff <= stable_pressed_in;
            press_time_ff     <= press_time_in;
            long_sent_ff      <= long_sent_in;
            last_mode_ff      <= last_mode_in;
            event_ff          <= event_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_event_ff   <= rsp_event_in;
      rsp_pressed_ff <= rsp_pressed_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pending_event  = rsp_event_ff;
   assign rsp_button_pressed = rsp_pressed_ff;

   `BDLP_ASSERT_NEXT(a_fire_gives_rsp, clock, reset, req_fire, rsp_valid_ff)
   `BDLP_ASSERT_NEXT(a_rsp_state_match, clock, reset, req_fire,
                     rsp_pressed_ff == stable_pressed_ff)
   `BDLP_ASSERT_IMPLIES(a_no_short_kept, clock, reset, 1'b1,
                        event_ff != bdlp_pkg::EV_SHORT)
   `BDLP_ASSERT_NEXT(a_event_sticky, clock, reset,
                     req_fire && !req_consume_event && event_ff != bdlp_pkg::EV_NONE,
                     event_ff == $past(event_ff))
   `BDLP_ASSERT_NEXT(a_disabled_frozen, clock, reset, req_fire && !button_enable_ff,
                     stable_pressed_ff == $past(stable_pressed_ff))

endmodule
